[src/pva_pkg.sv]
// Shared types, constants and sine table generator of the polar vector accumulator.
package pva_pkg;

    localparam int DIST_WIDTH_DEF   = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int ANGLE_IN_W  = 10;
    localparam int ANGLE_OUT_W = 9;
    localparam int ZW          = 27;
    localparam int ITER_W      = 5;
    localparam int SIN_W       = 26;
    localparam int GAIN_FRAC   = 30;
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    typedef logic [SIN_W-1:0] sin_tab_t [0:90];

    // atan(2^-i) in degrees scaled by 2^16
    localparam logic [ZW-1:0] ATAN_DEG16 [0:31] = '{
        27'd2949120, 27'd1740967, 27'd919879, 27'd466945,
        27'd234379,  27'd117304,  27'd58666,  27'd29335,
        27'd14668,   27'd7334,    27'd3667,   27'd1833,
        27'd917,     27'd458,     27'd229,    27'd115,
        27'd57,      27'd29,      27'd14,     27'd7,
        27'd4,       27'd2,       27'd1,      27'd0,
        27'd0,       27'd0,       27'd0,      27'd0,
        27'd0,       27'd0,       27'd0,      27'd0
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_MAC,
        S_PREP,
        S_ITER,
        S_GAIN_LO,
        S_GAIN_HI,
        S_ROUND,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              look;
        logic              mac;
        logic [2:0]        mac_ph;
        logic              prep;
        logic              iter;
        logic [ITER_W-1:0] it;
        logic              gain_lo;
        logic              gain_hi;
        logic              round;
        logic              emit;
    } cmd_t;

    typedef struct packed {
        logic sum_zero;
        logic last;
    } status_t;

    // Sine table for 0..90 degrees in Q1.fb, built by CORDIC rotation in Q1.30.
    function automatic sin_tab_t build_sin_tab(input int fb, input int steps);
        sin_tab_t t;
        longint   x;
        longint   y;
        longint   z;
        longint   xs;
        longint   ys;
        for (int d = 0; d <= 90; d++)
        begin
            x = longint'(KINV_Q30);
            y = 0;
            z = longint'(d) * 65536;
            for (int i = 0; i < steps && i < 32; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_DEG16[i]);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_DEG16[i]);
                end
            end
            if (y < 0)
                y = 0;
            y = (y + (longint'(1) << (29 - fb))) >>> (30 - fb);
            if (y > (longint'(1) << fb))
                y = longint'(1) << fb;
            t[d] = SIN_W'(y);
        end
        t[0]  = '0;
        t[90] = SIN_W'(longint'(1) << fb);
        return t;
    endfunction

endpackage

[src/pva_ctrl.sv]
// Sequencer of the polar vector accumulator: state machine, counters, result valid.
module pva_ctrl
    import pva_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [ITER_W-1:0] LAST_IT = ITER_W'(CORDIC_STEPS - 1);
    localparam logic [2:0]        MAC_END = 3'd4;

    state_t            state_reg, state_next;
    logic [2:0]        mac_reg, mac_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic              out_valid_reg, out_valid_next;
    logic              emit_fire;

    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mac_reg       <= '0;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mac_reg       <= mac_next;
            it_reg        <= it_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next     = state_reg;
        mac_next       = mac_reg;
        it_next        = it_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                mac_next   = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                mac_next = mac_reg + 3'd1;
                if (mac_reg == MAC_END)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                it_next    = '0;
                state_next = status.sum_zero ? S_ROUND : S_ITER;
            end
            S_ITER:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == LAST_IT)
                    state_next = S_GAIN_LO;
            end
            S_GAIN_LO: state_next = S_GAIN_HI;
            S_GAIN_HI: state_next = S_ROUND;
            S_ROUND:   state_next = status.last ? S_EMIT : S_IDLE;
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == S_IDLE) && in_valid;
        cmd.look    = (state_reg == S_LOOK);
        cmd.mac     = (state_reg == S_MAC);
        cmd.mac_ph  = mac_reg;
        cmd.prep    = (state_reg == S_PREP);
        cmd.iter    = (state_reg == S_ITER);
        cmd.it      = it_reg;
        cmd.gain_lo = (state_reg == S_GAIN_LO);
        cmd.gain_hi = (state_reg == S_GAIN_HI);
        cmd.round   = (state_reg == S_ROUND);
        cmd.emit    = emit_fire;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[src/pva_datapath.sv]
// Datapath: trig lookup, multiply-accumulate, CORDIC vectoring, gain and rounding.
module pva_datapath
    import pva_pkg::*;
#(
    parameter int DIST_WIDTH   = DIST_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic [DIST_WIDTH-1:0]         in_distance,
    input  logic signed [ANGLE_IN_W-1:0]  in_angle,
    input  logic                          in_last,
    output logic [DIST_WIDTH-1:0]         out_distance,
    output logic signed [ANGLE_OUT_W-1:0] out_angle,
    output logic                          out_saturated
);

    localparam int TW = FRAC_BITS + 2;
    localparam int PW = DIST_WIDTH + TW + 1;
    localparam int XW = DIST_WIDTH + FRAC_BITS + 4;
    localparam int UW = XW + GAIN_FRAC;
    localparam int MW = XW + GAIN_FRAC + 1;
    localparam sin_tab_t SIN_TAB = build_sin_tab(FRAC_BITS, CORDIC_STEPS);
    localparam logic [MW-1:0] DIST_MAX = MW'((64'd1 << DIST_WIDTH) - 64'd1);
    localparam logic [MW-1:0] HALF     = MW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ZW-1:0] Z180 = ZW'(180 * 65536);

    // sine and cosine of a whole-degree angle, returned as {sin, cos}
    function automatic logic [2*TW-1:0] trig_of(input logic signed [ANGLE_IN_W-1:0] ang);
        logic signed [ANGLE_IN_W:0] a;
        logic [6:0]                 r;
        logic [1:0]                 q;
        logic signed [TW-1:0]       sr;
        logic signed [TW-1:0]       sn;
        logic signed [TW-1:0]       s;
        logic signed [TW-1:0]       c;
        a = {ang[ANGLE_IN_W-1], ang};
        if (a < 11'sd0)
            a = a + 11'sd360;
        if (a < 11'sd0)
            a = a + 11'sd360;
        if (a >= 11'sd360)
            a = a - 11'sd360;
        if (a >= 11'sd270)
        begin
            q = 2'd3;
            r = 7'(a - 11'sd270);
        end
        else if (a >= 11'sd180)
        begin
            q = 2'd2;
            r = 7'(a - 11'sd180);
        end
        else if (a >= 11'sd90)
        begin
            q = 2'd1;
            r = 7'(a - 11'sd90);
        end
        else
        begin
            q = 2'd0;
            r = 7'(a);
        end
        sr = $signed(SIN_TAB[r][TW-1:0]);
        sn = $signed(SIN_TAB[7'd90 - r][TW-1:0]);
        case (q)
            2'd0:
            begin
                s = sr;
                c = sn;
            end
            2'd1:
            begin
                s = sn;
                c = -sr;
            end
            2'd2:
            begin
                s = -sr;
                c = -sn;
            end
            default:
            begin
                s = -sn;
                c = sr;
            end
        endcase
        return {s, c};
    endfunction

    logic [DIST_WIDTH-1:0]         in_dist_reg;
    logic signed [ANGLE_IN_W-1:0]  in_ang_reg;
    logic                          last_reg;
    logic [DIST_WIDTH-1:0]         acc_dist_reg;
    logic signed [ANGLE_OUT_W-1:0] acc_ang_reg;
    logic                          sat_reg;
    logic signed [TW-1:0]          s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [XW-1:0]          x_reg, y_reg;
    logic signed [ZW-1:0]          z_reg;
    logic                          zero_reg;
    logic [GAIN_FRAC-1:0]          plo_reg;
    logic [MW-1:0]                 mag_reg;
    logic [DIST_WIDTH-1:0]         out_dist_reg;
    logic signed [ANGLE_OUT_W-1:0] out_ang_reg;
    logic                          out_sat_reg;

    logic [2*TW-1:0]      t1, t2;
    logic [DIST_WIDTH-1:0] opa;
    logic signed [TW-1:0] opt;
    logic signed [PW-1:0] prod_ext;
    logic signed [XW-1:0] prod_x;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] atan_v;
    logic [UW-1:0]        ux;
    logic [MW-1:0]        mag_r;
    logic                 sat_now;
    logic signed [ZW-1:0] deg;
    logic signed [ZW-1:0] zneg;

    assign t1 = trig_of({acc_ang_reg[ANGLE_OUT_W-1], acc_ang_reg});
    assign t2 = trig_of(in_ang_reg);

    always_comb
    begin
        case (cmd.mac_ph)
            3'd0:
            begin
                opa = acc_dist_reg;
                opt = c1_reg;
            end
            3'd1:
            begin
                opa = in_dist_reg;
                opt = c2_reg;
            end
            3'd2:
            begin
                opa = acc_dist_reg;
                opt = s1_reg;
            end
            default:
            begin
                opa = in_dist_reg;
                opt = s2_reg;
            end
        endcase
    end

    assign prod_ext = $signed({1'b0, opa}) * opt;
    assign prod_x   = {{(XW - PW){prod_reg[PW-1]}}, prod_reg};
    assign xs       = x_reg >>> cmd.it;
    assign ys       = y_reg >>> cmd.it;
    assign atan_v   = $signed(ATAN_DEG16[cmd.it]);
    assign ux       = x_reg[XW-1] ? '0 : UW'(unsigned'(x_reg));
    assign mag_r    = (mag_reg + HALF) >> FRAC_BITS;
    assign sat_now  = !zero_reg && (mag_r > DIST_MAX);
    assign zneg     = -z_reg;

    // round half away from zero, clamp to +-180
    always_comb
    begin
        if (z_reg >= 0)
            deg = (z_reg + ZW'(32768)) >>> 16;
        else
            deg = -((zneg + ZW'(32768)) >>> 16);
        if (deg > ZW'(180))
            deg = ZW'(180);
        if (deg < -ZW'(180))
            deg = -ZW'(180);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_dist_reg <= '0;
            acc_ang_reg  <= '0;
            sat_reg      <= 1'b0;
        end
        else if (cmd.round)
        begin
            if (zero_reg)
            begin
                acc_dist_reg <= '0;
                acc_ang_reg  <= '0;
            end
            else
            begin
                acc_dist_reg <= sat_now ? DIST_MAX[DIST_WIDTH-1:0] : mag_r[DIST_WIDTH-1:0];
                acc_ang_reg  <= ANGLE_OUT_W'(deg);
            end
            sat_reg <= sat_reg | sat_now;
        end
        else if (cmd.emit)
        begin
            acc_dist_reg <= '0;
            acc_ang_reg  <= '0;
            sat_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_dist_reg <= in_distance;
            in_ang_reg  <= in_angle;
            last_reg    <= in_last;
        end
        if (cmd.look)
        begin
            {s1_reg, c1_reg} <= t1;
            {s2_reg, c2_reg} <= t2;
        end
        if (cmd.mac)
        begin
            prod_reg <= prod_ext;
            case (cmd.mac_ph)
                3'd1:    x_reg <= prod_x;
                3'd2:    x_reg <= x_reg + prod_x;
                3'd3:    y_reg <= prod_x;
                3'd4:    y_reg <= y_reg + prod_x;
                default: ;
            endcase
        end
        if (cmd.prep)
        begin
            zero_reg <= (x_reg == '0) && (y_reg == '0);
            if (x_reg[XW-1])
            begin
                z_reg <= y_reg[XW-1] ? -Z180 : Z180;
                x_reg <= -x_reg;
                y_reg <= -y_reg;
            end
            else
                z_reg <= '0;
        end
        if (cmd.iter)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_v;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_v;
            end
        end
        if (cmd.gain_lo)
            plo_reg <= GAIN_FRAC'(({{GAIN_FRAC{1'b0}}, ux[GAIN_FRAC-1:0]}
                       * {{GAIN_FRAC{1'b0}}, KINV_Q30}) >> GAIN_FRAC);
        if (cmd.gain_hi)
            mag_reg <= MW'(ux[UW-1:GAIN_FRAC]) * MW'(KINV_Q30) + MW'(plo_reg);
        if (cmd.emit)
        begin
            out_dist_reg <= acc_dist_reg;
            out_ang_reg  <= acc_ang_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign status.sum_zero = (x_reg == '0) && (y_reg == '0);
    assign status.last     = last_reg;
    assign out_distance    = out_dist_reg;
    assign out_angle       = out_ang_reg;
    assign out_saturated   = out_sat_reg;

endmodule

[src/polar_vector_accumulator.sv]
// Top level of the polar vector accumulator: ports, sequencer and datapath.
//
//  channel  dir  request carries                               handshake
//  s_axis   in   distance, angle (tdata), end of run (tlast)   tvalid/tready
//  m_axis   out  distance, angle (tdata), saturated (tuser)    tvalid/tready
//
// A request runs through trig lookup, four products through one shared multiplier,
// one CORDIC vectoring step per cycle, two gain products and a rounding step. A
// sum that is exactly the zero vector skips the CORDIC and gain steps. A request
// marked last adds an emit step that moves the resultant into the output register.
// The next request is accepted while a result waits on m_axis; only a second
// result stalls until it is taken.
// Reset (rst_n, asynchronous) clears the resultant, flag and handshake state.
module polar_vector_accumulator
    import pva_pkg::*;
#(
    parameter int DIST_WIDTH   = DIST_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int IN_TW        = ((DIST_WIDTH + ANGLE_IN_W + 7) / 8) * 8,
    parameter int OUT_TW       = ((DIST_WIDTH + ANGLE_OUT_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // in_distance, in_angle, zero pad
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,   // out_distance, out_angle, zero pad
    output logic              m_axis_tuser    // saturated
);

    cmd_t                          cmd;
    status_t                       status;
    logic [DIST_WIDTH-1:0]         out_distance;
    logic signed [ANGLE_OUT_W-1:0] out_angle;

    pva_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pva_datapath #(
        .DIST_WIDTH   (DIST_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_distance   (s_axis_tdata[DIST_WIDTH-1:0]),
        .in_angle      ($signed(s_axis_tdata[DIST_WIDTH+ANGLE_IN_W-1:DIST_WIDTH])),
        .in_last       (s_axis_tlast),
        .out_distance  (out_distance),
        .out_angle     (out_angle),
        .out_saturated (m_axis_tuser)
    );

    // pack result, zero-fill to whole bytes
    assign m_axis_tdata = OUT_TW'({out_angle, out_distance});

    // a new result appears only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.emit))
        else $error("result valid rose without emit");

    // an accepted request starts the lookup on the next cycle
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.look)
        else $error("accepted request did not start lookup");

    // angle stays in atan2 range
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_angle <= 9'sd180 && out_angle >= -9'sd180))
        else $error("result angle out of range");

endmodule
